FILE: sv/rgb_to_hsl_converter_macros.svh
// assertion macros for the rgb to hsl converter
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

`ifndef SYNTH
// checked while out of reset
`define RHSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define RHSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHSL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/rhsl_pkg.sv
// shared constants of the rgb to hsl converter
package rhsl_pkg;

    // hue circle: six sectors of sixty degrees each
    localparam int SECTORS        = 6;
    localparam int DEG_PER_SECTOR = 60;

endpackage

FILE: sv/rhsl_prep.sv
// front end: max/min, chroma, lightness and the two dividend/divisor pairs
module rhsl_prep #(
    parameter int CHANNEL_BITS  = 8,
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CHANNEL_BITS + $clog2(2 * rhsl_pkg::SECTORS
                 * (rhsl_pkg::DEG_PER_SECTOR << HUE_FRAC_BITS) + 2) - 1:0] o_hue_num,
    output logic [CHANNEL_BITS:0]   o_hue_den,
    output logic [2*CHANNEL_BITS+1:0] o_sat_num,
    output logic [CHANNEL_BITS:0]   o_sat_den,
    output logic [CHANNEL_BITS-1:0] o_light,
    output logic                    o_grey
);

    localparam int CB     = CHANNEL_BITS;
    localparam int HUE_K  = rhsl_pkg::DEG_PER_SECTOR << HUE_FRAC_BITS;
    localparam int HUE_K2 = 2 * HUE_K;
    localparam int NHW    = CB + $clog2(2 * rhsl_pkg::SECTORS * HUE_K + 2);
    localparam int NSW    = 2 * CB + 2;
    localparam int NUM_W  = CB + 3;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam logic [CB:0] MAX_V   = {1'b0, {CB{1'b1}}};
    localparam logic [CB:0] TWO_MAX = {{CB{1'b1}}, 1'b0};

    // stage handshake
    logic r_a_vld, r_b_vld, r_c_vld;
    logic w_en_a, w_en_b, w_en_c;

    assign w_en_c  = !r_c_vld || i_ready;
    assign w_en_b  = !r_b_vld || w_en_c;
    assign w_en_a  = !r_a_vld || w_en_b;
    assign o_ready = w_en_a;
    assign o_valid = r_c_vld;

    // stage a: sector, extremes, signed difference of the other two channels
    logic          w_ge_rg, w_ge_rb, w_ge_gb;
    logic [CB-1:0] w_lo_rg;
    logic [1:0]    n_a_sec;
    logic [CB-1:0] n_a_hi, n_a_lo;
    logic [CB:0]   n_a_sd;
    logic [1:0]    r_a_sec;
    logic [CB-1:0] r_a_hi, r_a_lo;
    logic [CB:0]   r_a_sd;

    assign w_ge_rg = i_red >= i_green;
    assign w_ge_rb = i_red >= i_blue;
    assign w_ge_gb = i_green >= i_blue;
    assign w_lo_rg = w_ge_rg ? i_green : i_red;
    assign n_a_lo  = (w_lo_rg <= i_blue) ? w_lo_rg : i_blue;

    always_comb begin
        if (w_ge_rg && w_ge_rb) begin
            n_a_sec = SEC_RED;
            n_a_hi  = i_red;
            n_a_sd  = {1'b0, i_green} - {1'b0, i_blue};
        end else if (w_ge_gb) begin
            n_a_sec = SEC_GREEN;
            n_a_hi  = i_green;
            n_a_sd  = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_a_sec = SEC_BLUE;
            n_a_hi  = i_blue;
            n_a_sd  = {1'b0, i_red} - {1'b0, i_green};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_sec <= n_a_sec;
            r_a_hi  <= n_a_hi;
            r_a_lo  <= n_a_lo;
            r_a_sd  <= n_a_sd;
        end
    end

    // stage b: chroma, lightness, saturation divisor, hue numerator
    logic [CB-1:0]    n_b_c;
    logic [CB:0]      w_sum;
    logic [CB+1:0]    w_sum_rnd;
    logic [CB-1:0]    n_b_den;
    logic [NUM_W-1:0] w_mult;
    logic [NUM_W:0]   w_num_full;
    logic [CB-1:0]    r_b_c, r_b_den, r_b_light;
    logic [NUM_W-1:0] r_b_num;
    logic             r_b_grey;

    assign n_b_c     = r_a_hi - r_a_lo;
    assign w_sum     = {1'b0, r_a_hi} + {1'b0, r_a_lo};
    assign w_sum_rnd = {1'b0, w_sum} + {{(CB+1){1'b0}}, 1'b1};

    always_comb begin
        if (w_sum <= MAX_V) begin
            n_b_den = w_sum[CB-1:0];
        end else begin
            n_b_den = CB'(TWO_MAX - w_sum);
        end
    end

    // whole sectors of chroma keep the numerator non-negative
    always_comb begin
        case (r_a_sec)
            SEC_RED: begin
                if (r_a_sd[CB]) begin
                    w_mult = (NUM_W'(n_b_c) << 2) + (NUM_W'(n_b_c) << 1);
                end else begin
                    w_mult = '0;
                end
            end
            SEC_GREEN: w_mult = NUM_W'(n_b_c) << 1;
            default:   w_mult = NUM_W'(n_b_c) << 2;
        endcase
    end

    assign w_num_full = {1'b0, w_mult} + {{(NUM_W-CB){r_a_sd[CB]}}, r_a_sd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_c     <= n_b_c;
            r_b_den   <= n_b_den;
            r_b_light <= w_sum_rnd[CB:1];
            r_b_num   <= w_num_full[NUM_W-1:0];
            r_b_grey  <= (n_b_c == '0);
        end
    end

    // stage c: rounding dividends, both of the form 2*n + d over 2*d
    logic [NSW-1:0] w_cmax;
    logic [NHW-1:0] r_c_hnum;
    logic [CB:0]    r_c_hden, r_c_sden;
    logic [NSW-1:0] r_c_snum;
    logic [CB-1:0]  r_c_light;
    logic           r_c_grey;

    assign w_cmax = (NSW'(r_b_c) << CB) - NSW'(r_b_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en_c) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_hnum  <= NHW'(r_b_num) * NHW'(HUE_K2) + NHW'(r_b_c);
            r_c_hden  <= {r_b_c, 1'b0};
            r_c_snum  <= (w_cmax << 1) + NSW'(r_b_den);
            r_c_sden  <= {r_b_den, 1'b0};
            r_c_light <= r_b_light;
            r_c_grey  <= r_b_grey;
        end
    end

    assign o_hue_num = r_c_hnum;
    assign o_hue_den = r_c_hden;
    assign o_sat_num = r_c_snum;
    assign o_sat_den = r_c_sden;
    assign o_light   = r_c_light;
    assign o_grey    = r_c_grey;

endmodule

FILE: sv/rhsl_div.sv
// pipelined restoring divider, one quotient bit per stage, with side payload
module rhsl_div #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 8,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int EXT_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int REM_N = (QUO_W > 1) ? QUO_W - 1 : 1;

    // per-stage registers; the last stage keeps no remainder
    logic              r_vld  [QUO_W];
    logic [NUM_W-1:0]  r_rem  [REM_N];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    // stage inputs
    wire               p_vld  [QUO_W];
    wire  [NUM_W-1:0]  p_rem  [QUO_W];
    wire  [DEN_W-1:0]  p_den  [QUO_W];
    wire  [QUO_W-1:0]  p_quo  [QUO_W];
    wire  [SIDE_W-1:0] p_side [QUO_W];

    wire  [QUO_W:0]    w_en;

    assign w_en[QUO_W] = i_ready;
    assign o_ready     = w_en[0];
    assign o_valid     = r_vld[QUO_W-1];
    assign o_quo       = r_quo[QUO_W-1];
    assign o_side      = r_side[QUO_W-1];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int B = QUO_W - 1 - j;

        logic [EXT_W-1:0] w_shift;
        logic [EXT_W-1:0] w_rem_ext;
        logic             w_ge;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (j == 0) begin : g_first
            assign p_vld[j]  = i_valid;
            assign p_rem[j]  = i_num;
            assign p_den[j]  = i_den;
            assign p_quo[j]  = '0;
            assign p_side[j] = i_side;
        end else begin : g_next
            assign p_vld[j]  = r_vld[j-1];
            assign p_rem[j]  = r_rem[j-1];
            assign p_den[j]  = r_den[j-1];
            assign p_quo[j]  = r_quo[j-1];
            assign p_side[j] = r_side[j-1];
        end

        assign w_en[j]   = !r_vld[j] || w_en[j+1];
        assign w_shift   = EXT_W'(p_den[j]) << B;
        assign w_rem_ext = EXT_W'(p_rem[j]);
        assign w_ge      = w_rem_ext >= w_shift;
        assign n_rem     = w_ge ? NUM_W'(w_rem_ext - w_shift) : p_rem[j];

        always_comb begin
            n_quo    = p_quo[j];
            n_quo[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (w_en[j]) begin
                r_vld[j] <= p_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                r_den[j]  <= p_den[j];
                r_quo[j]  <= n_quo;
                r_side[j] <= p_side[j];
            end
        end

        if (j < QUO_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_en[j]) begin
                    r_rem[j] <= n_rem;
                end
            end
        end
    end

endmodule

FILE: sv/rgb_to_hsl_converter.sv
// top level of the rgb to hsl converter: stream ports and pipeline assembly

// Streaming RGB to HSL converter. Each input item is one pixel and gives
// exactly one result item: hue in 1/2^HUE_FRAC_BITS degree, saturation and
// lightness scaled so that all ones means 1.0. One item can be accepted on
// every clock while the output is not stalled; the pipeline is made of three
// front-end stages, the hue divider with one stage per quotient bit and the
// saturation divider with one stage per channel bit. Every stage has its own
// valid bit and loads whenever it is empty or the stage after it moves, so a
// stall on the output only backs up as far as the first empty stage and
// input keeps flowing into the gaps. All quotients round half up; grey
// pixels give zero hue and saturation, and a hue that rounds to a full turn
// reads as zero.

`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter #(
    parameter int CHANNEL_BITS  = 8,
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input item
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata from bit 0: red, green, blue, zero fill to whole bytes
    input  logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // result item
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // tdata from bit 0: hue, saturation, lightness, zero fill to whole bytes
    output logic [(($clog2(rhsl_pkg::SECTORS * (rhsl_pkg::DEG_PER_SECTOR
                 << HUE_FRAC_BITS) + 1) + 2 * CHANNEL_BITS + 7) / 8) * 8 - 1:0]
                 o_m_axis_tdata
);

    localparam int CB       = CHANNEL_BITS;
    localparam int HUE_K    = rhsl_pkg::DEG_PER_SECTOR << HUE_FRAC_BITS;
    localparam int HUE_FULL = rhsl_pkg::SECTORS * HUE_K;
    localparam int HUE_W    = $clog2(HUE_FULL + 1);
    localparam int NHW      = CB + $clog2(2 * rhsl_pkg::SECTORS * HUE_K + 2);
    localparam int NSW      = 2 * CB + 2;
    localparam int OUT_W    = ((HUE_W + 2 * CB + 7) / 8) * 8;
    localparam int HSIDE_W  = NSW + (CB + 1) + CB + 1;
    localparam int SSIDE_W  = HUE_W + CB + 1;

    // front end
    logic             w_prep_vld, w_prep_rdy;
    logic [NHW-1:0]   w_hue_num;
    logic [CB:0]      w_hue_den;
    logic [NSW-1:0]   w_sat_num;
    logic [CB:0]      w_sat_den;
    logic [CB-1:0]    w_prep_light;
    logic             w_prep_grey;

    rhsl_prep #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_red     (i_s_axis_tdata[CB-1:0]),
        .i_green   (i_s_axis_tdata[2*CB-1:CB]),
        .i_blue    (i_s_axis_tdata[3*CB-1:2*CB]),
        .o_valid   (w_prep_vld),
        .i_ready   (w_prep_rdy),
        .o_hue_num (w_hue_num),
        .o_hue_den (w_hue_den),
        .o_sat_num (w_sat_num),
        .o_sat_den (w_sat_den),
        .o_light   (w_prep_light),
        .o_grey    (w_prep_grey)
    );

    // hue divider; the saturation operands ride along
    logic               w_hdiv_vld, w_hdiv_rdy;
    logic [HUE_W-1:0]   w_hue_q;
    logic [HSIDE_W-1:0] w_hside;
    logic [NSW-1:0]     w_hs_num;
    logic [CB:0]        w_hs_den;
    logic [CB-1:0]      w_hs_light;
    logic               w_hs_grey;

    rhsl_div #(
        .NUM_W  (NHW),
        .DEN_W  (CB + 1),
        .QUO_W  (HUE_W),
        .SIDE_W (HSIDE_W)
    ) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_vld),
        .o_ready (w_prep_rdy),
        .i_num   (w_hue_num),
        .i_den   (w_hue_den),
        .i_side  ({w_sat_num, w_sat_den, w_prep_light, w_prep_grey}),
        .o_valid (w_hdiv_vld),
        .i_ready (w_hdiv_rdy),
        .o_quo   (w_hue_q),
        .o_side  (w_hside)
    );

    assign {w_hs_num, w_hs_den, w_hs_light, w_hs_grey} = w_hside;

    // saturation divider; the raw hue rides along
    logic               w_sdiv_vld;
    logic [CB-1:0]      w_sat_q;
    logic [SSIDE_W-1:0] w_sside;
    logic [HUE_W-1:0]   w_ss_hue;
    logic [CB-1:0]      w_light;
    logic               w_grey;

    rhsl_div #(
        .NUM_W  (NSW),
        .DEN_W  (CB + 1),
        .QUO_W  (CB),
        .SIDE_W (SSIDE_W)
    ) u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hdiv_vld),
        .o_ready (w_hdiv_rdy),
        .i_num   (w_hs_num),
        .i_den   (w_hs_den),
        .i_side  ({w_hue_q, w_hs_light, w_hs_grey}),
        .o_valid (w_sdiv_vld),
        .i_ready (i_m_axis_tready),
        .o_quo   (w_sat_q),
        .o_side  (w_sside)
    );

    assign {w_ss_hue, w_light, w_grey} = w_sside;

    // grey pixels zero hue and saturation; a full turn wraps to zero
    logic [HUE_W-1:0] w_hue;
    logic [CB-1:0]    w_sat;

    assign w_hue = (w_grey || (w_ss_hue == HUE_W'(HUE_FULL))) ? '0 : w_ss_hue;
    assign w_sat = w_grey ? '0 : w_sat_q;

    assign o_m_axis_tvalid = w_sdiv_vld;
    assign o_m_axis_tdata  = OUT_W'({w_light, w_sat, w_hue});

    // checks
    `RHSL_ASSERT(a_hue_range, i_clk, i_rst_n, o_m_axis_tvalid |-> (w_hue < HUE_W'(HUE_FULL)), "hue beyond full turn")
    `RHSL_ASSERT(a_black_grey, i_clk, i_rst_n, (o_m_axis_tvalid && (w_light == '0)) |-> ((w_sat == '0) && (w_hue == '0)), "black pixel with hue or saturation")
    `RHSL_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready, "input stalled with empty output stage")
    `RHSL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the rgb to hsl converter
module testbench;

    // ------------------------------------------------------------------
    // widths and constants of the default configuration
    // ------------------------------------------------------------------
    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int IN_W          = ((3 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int HUE_W         = $clog2(rhsl_pkg::SECTORS
                                   * (rhsl_pkg::DEG_PER_SECTOR << HUE_FRAC_BITS) + 1);
    localparam int OUT_W         = ((HUE_W + 2 * CHANNEL_BITS + 7) / 8) * 8;
    localparam longint unsigned CH_MAX = (64'd1 << CHANNEL_BITS) - 1;
    // hue units in one sector, and in the full turn
    localparam longint unsigned SECTOR_UNITS = rhsl_pkg::DEG_PER_SECTOR << HUE_FRAC_BITS;
    localparam longint unsigned TURN_UNITS   = rhsl_pkg::SECTORS * SECTOR_UNITS;

    localparam int RANDOM_PIXELS = 1500;
    localparam int DRAIN_CYCLES  = 60;       // well past the length of the pipeline
    localparam int CYCLE_LIMIT   = 400000;   // a correct run ends well before this limit

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] light;
        logic [CHANNEL_BITS-1:0] sat;
        logic [HUE_W-1:0]        hue;
    } hsl_t;

    // ------------------------------------------------------------------
    // scoreboard: predicts hsl for every accepted pixel, checks results
    // ------------------------------------------------------------------
    class hsl_tracker;
        hsl_t        pending_hsl[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // exact integer conversion, every quotient rounds half up
        function hsl_t rgb_to_hsl(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                                  logic [CHANNEL_BITS-1:0] b);
            longint unsigned rv, gv, bv, hi, lo, chroma, sum, num, den, h, s;
            hsl_t res;
            rv = r;
            gv = g;
            bv = b;
            hi = rv;
            lo = rv;
            if (gv > hi) hi = gv;
            if (bv > hi) hi = bv;
            if (gv < lo) lo = gv;
            if (bv < lo) lo = bv;
            chroma = hi - lo;
            sum    = hi + lo;
            h = 0;
            s = 0;
            if (chroma != 0) begin
                // ties: red first, then green; whole sectors keep numerators positive
                if (hi == rv) begin
                    if (gv >= bv) num = gv - bv;
                    else num = 6 * chroma - (bv - gv);
                end else if (hi == gv) begin
                    num = 2 * chroma + bv - rv;
                end else begin
                    num = 4 * chroma + rv - gv;
                end
                h = (2 * SECTOR_UNITS * num + chroma) / (2 * chroma);
                if (h >= TURN_UNITS) h -= TURN_UNITS;
                den = (sum <= CH_MAX) ? sum : 2 * CH_MAX - sum;
                s = (2 * chroma * CH_MAX + den) / (2 * den);
            end
            res.hue   = h[HUE_W-1:0];
            res.sat   = s[CHANNEL_BITS-1:0];
            res.light = CHANNEL_BITS'((sum + 1) >> 1);
            return res;
        endfunction

        function void note_pixel(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
                                 logic [CHANNEL_BITS-1:0] b);
            pending_hsl.push_back(rgb_to_hsl(r, g, b));
        endfunction

        function void check_hsl(logic [OUT_W-1:0] data);
            hsl_t want, got;
            got = data[HUE_W + 2 * CHANNEL_BITS - 1:0];
            if (pending_hsl.size() == 0) begin
                $error("result item with no pixel waiting: hue %0d sat %0d light %0d",
                       got.hue, got.sat, got.light);
                errors++;
                return;
            end
            want = pending_hsl.pop_front();
            if (got.hue !== want.hue) begin
                $error("hue: expected %0d, got %0d", want.hue, got.hue);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $error("saturation: expected %0d, got %0d", want.sat, got.sat);
                errors++;
            end
            if (got.light !== want.light) begin
                $error("lightness: expected %0d, got %0d", want.light, got.light);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // tdata from bit 0: red, green, blue
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // tdata from bit 0: hue, saturation, lightness, zero fill
    logic [OUT_W-1:0]  o_m_axis_tdata;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rgb_to_hsl_converter #(
        .CHANNEL_BITS  (CHANNEL_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    hsl_tracker  tracker;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycles;

    // ------------------------------------------------------------------
    // receiver stalls, result checking and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tracker.check_hsl(o_m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pixel driver
    // ------------------------------------------------------------------
    // offers one pixel, with random idle cycles ahead of it, until accepted
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_pixel(r, g, b);
    endtask

    function automatic logic [7:0] clamp_channel(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // random pixels with extra weight on grey, near grey, ties and extremes
    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        int base;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(9))
            5: begin
                base = $urandom_range(255);
                r = clamp_channel(base + $urandom_range(6) - 3);
                g = clamp_channel(base + $urandom_range(6) - 3);
                b = clamp_channel(base + $urandom_range(6) - 3);
            end
            6: begin
                // two channels tie
                case ($urandom_range(2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            7: begin
                if ($urandom_range(1)) r = {8{r[0]}};
                if ($urandom_range(1)) g = {8{g[0]}};
                if ($urandom_range(1)) b = {8{b[0]}};
            end
            8: begin
                r = r | 8'hf0;
                g = g | 8'hf0;
                b = b | 8'hf0;
            end
            9: begin
                r = r & 8'h0f;
                g = g & 8'h0f;
                b = b & 8'h0f;
            end
            default: begin
            end
        endcase
        send_pixel(r, g, b);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        tracker         = new();
        cycles          = 0;
        send_idle_pct   = 28;
        recv_idle_pct   = 85;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: greys, primaries, ties and rounding corners
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);     // red
        send_pixel(8'd0,   8'd255, 8'd0);     // green
        send_pixel(8'd0,   8'd0,   8'd255);   // blue
        send_pixel(8'd255, 8'd255, 8'd0);     // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255);   // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255);   // red and blue tie
        send_pixel(8'd255, 8'd0,   8'd1);     // just short of a full turn
        send_pixel(8'd200, 8'd50,  8'd100);   // red largest, blue over green
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd50,  8'd200, 8'd100);
        send_pixel(8'd100, 8'd200, 8'd50);
        send_pixel(8'd50,  8'd100, 8'd200);
        send_pixel(8'd100, 8'd50,  8'd200);
        send_pixel(8'd1,   8'd0,   8'd0);     // smallest chroma, dark
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);   // smallest chroma, bright
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd128, 8'd127, 8'd127);   // lightness rounds half up
        send_pixel(8'd127, 8'd128, 8'd127);
        send_pixel(8'd170, 8'd85,  8'd0);

        // random: sender idles lightly, receiver heavily
        for (int n = 0; n < RANDOM_PIXELS / 3; n++) send_random_pixel();
        // the other way round
        send_idle_pct = 85;
        recv_idle_pct = 28;
        for (int n = 0; n < RANDOM_PIXELS / 3; n++) send_random_pixel();
        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < RANDOM_PIXELS / 3; n++) send_random_pixel();

        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending_hsl.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending_hsl.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/rhsl_pkg.sv
sv/rhsl_prep.sv
sv/rhsl_div.sv
sv/rgb_to_hsl_converter.sv
tb/testbench.sv
